@@ rtl/cd_audio_command_port_assert.svh @@
`ifndef CD_AUDIO_COMMAND_PORT_ASSERT_SVH
`define CD_AUDIO_COMMAND_PORT_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define CDAP_ASSERT_NOW(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("cdap assertion failed");

// Condition implies consequence in the following cycle.
`define CDAP_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("cdap assertion failed");

`endif

@@ rtl/cdap_pkg.sv @@
`timescale 1ns / 1ps
package cdap_pkg;

  localparam int DATA_WORDS_DEF = 1024;
  localparam int MAX_TRACKS_DEF = 128;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_TOC   = 2'd3;

  localparam logic [15:0] ADDR_UNLOCK = 16'hf7fa;
  localparam logic [15:0] ADDR_CMD    = 16'hf7fe;
  localparam logic [15:0] ADDR_DATA   = 16'hf800;
  localparam logic [15:0] ADDR_REGS   = 16'hf7f6;
  localparam logic [15:0] UNLOCK_WORD = 16'hcd54;

  localparam logic [2:0] REG_ID_A   = 3'd3;
  localparam logic [2:0] REG_ID_B   = 3'd4;
  localparam logic [2:0] REG_ID_C   = 3'd5;
  localparam logic [2:0] REG_RESULT = 3'd6;
  localparam logic [2:0] REG_BUSY   = 3'd7;

  localparam logic [15:0] ID_WORD_A = 16'h5241;
  localparam logic [15:0] ID_WORD_B = 16'h5445;
  localparam logic [15:0] ID_WORD_C = 16'hcd54;

  localparam logic [7:0] OP_VERSION   = 8'h10;
  localparam logic [7:0] OP_PLAY      = 8'h11;
  localparam logic [7:0] OP_PLAY_LOOP = 8'h12;
  localparam logic [7:0] OP_PAUSE     = 8'h13;
  localparam logic [7:0] OP_RESUME    = 8'h14;
  localparam logic [7:0] OP_STATUS    = 8'h16;
  localparam logic [7:0] OP_PLAY_OFFS = 8'h1a;
  localparam logic [7:0] OP_SECTORS   = 8'h1b;
  localparam logic [7:0] OP_TRACKS    = 8'h27;

  localparam logic [1:0] LOOP_NONE  = 2'b00;
  localparam logic [1:0] LOOP_FORCE = 2'b01;

  typedef struct packed {
    logic [31:0] start_sec;
    logic [31:0] end_sec;
    logic [1:0]  loop_mode;
    logic [31:0] loop_offs;
  } toc_entry_t;

  localparam int TOC_BITS = $bits(toc_entry_t);

  function automatic logic [15:0] version_word(input logic [2:0] idx);
    logic [15:0] w;
    case (idx)
      3'd0: w = 16'h4d45;
      3'd1: w = 16'h4741;
      3'd2: w = 16'h5344;
      3'd3: w = 16'h0104;
      3'd4: w = 16'h0700;
      3'd5: w = 16'hffff;
      3'd6: w = 16'h1234;
      default: w = 16'h5678;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/cd_audio_command_port.sv @@
`timescale 1ns / 1ps
// Every bus read or write, tick or track table write gives one result. Commands do more
// work first: the version copy writes eight words to data memory, a parameter fetch reads
// its words one at a time, and a sector-range play walks the track table track by track.
// One item is in work at a time; the data memory and table memory ports set the pace.
// Reset is synchronous; afterwards a clearing pass writes DATA_WORDS zero words,
// one per cycle, with no item accepted until it is done.
`include "cd_audio_command_port_assert.svh"
module cd_audio_command_port
  import cdap_pkg::*;
#(
  parameter int DATA_WORDS = DATA_WORDS_DEF,
  parameter int MAX_TRACKS = MAX_TRACKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  logic [6:0]         cfg_write_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [15:0]        in_address,
  input  logic               in_byte_access,
  input  logic [15:0]        in_write_data,
  input  logic [6:0]         in_toc_index,
  input  logic signed [31:0] in_toc_start,
  input  logic signed [31:0] in_toc_end,
  input  logic signed [1:0]  in_toc_loop_mode,
  input  logic signed [31:0] in_toc_loop_offset,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_read_data,
  output logic               out_play_request,
  output logic [6:0]         out_play_track,
  output logic signed [31:0] out_play_sector
);

  localparam int DAW = $clog2(DATA_WORDS);
  localparam int TAW = $clog2(MAX_TRACKS);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RDWAIT, S_BWAIT, S_CMD, S_VER, S_PRD, S_PCAP,
    S_TRK_CHK, S_TRK_RD, S_TRK_USE, S_SEC_RD, S_SEC_CHK, S_WALK_TEST, S_WALK_RD,
    S_WALK_CHK, S_SEC_GO, S_TICK1, S_TICK2, S_DONE
  } state_t;

  state_t state_r;

  logic [DAW-1:0] clr_r;
  logic [2:0]     ver_r;
  logic [2:0]     pk_r;
  logic [2:0]     pn_r;
  logic [15:0]    prm_r [6];

  logic [1:0]  kind_r;
  logic [15:0] addr_r;
  logic        byte_r;
  logic [15:0] wd_r;
  logic [6:0]  tidx_r;
  toc_entry_t  twr_r;

  logic [6:0]  tcount_r;
  logic        init_r, play_r, pause_r, overlay_r;
  logic        tn_valid_r;
  logic [6:0]  tn_r;
  logic        loop_r;
  logic [31:0] end_r, lsec_r, cur_r, em1_r;
  logic [15:0] busy_r, res_r;
  logic [6:0]  ra_r;

  logic [15:0] rd_r;
  logic        req_r;
  logic [6:0]  req_trk_r;
  logic [31:0] req_sec_r;

  logic        out_valid_r;
  logic [15:0] out_rd_r;
  logic        out_req_r;
  logic [6:0]  out_trk_r;
  logic [31:0] out_sec_r;

  // Data memory and track table memory controls.
  logic                dm_we;
  logic [DAW-1:0]      dm_addr;
  logic [15:0]         dm_wdata, dm_rdata;
  logic                tm_we;
  logic [TAW-1:0]      tm_addr;
  logic [TOC_BITS-1:0] tm_rdata;

  logic [9:0]  word_idx;
  logic        word_ok;
  logic        data_hit;
  logic        ra_ok;
  toc_entry_t  ent;
  logic [7:0]  op;
  logic [7:0]  num;
  logic        trk_loop;
  logic [31:0] trk_offs;
  logic [31:0] p_s, p_e, p_l;

  assign word_idx = addr_r[10:1];
  assign word_ok  = ({1'b0, word_idx} < 11'(DATA_WORDS));
  assign data_hit = (addr_r >= ADDR_DATA) && word_ok;
  assign ra_ok    = ({1'b0, ra_r} < 8'(MAX_TRACKS));
  assign ent      = ra_ok ? toc_entry_t'(tm_rdata) : '0;
  assign op       = wd_r[15:8];
  assign num      = wd_r[7:0];
  assign p_s      = {prm_r[0], prm_r[1]};
  assign p_e      = {prm_r[2], prm_r[3]};
  assign p_l      = {prm_r[4], prm_r[5]};

  always_comb begin
    trk_loop = (op != OP_PLAY);
    trk_offs = (op == OP_PLAY_OFFS) ? p_s : 32'd0;
    if (ent.loop_mode != LOOP_NONE) begin
      trk_loop = (ent.loop_mode == LOOP_FORCE);
      trk_offs = ent.loop_offs;
    end
  end

  always_comb begin
    dm_we    = 1'b0;
    dm_addr  = word_idx[DAW-1:0];
    dm_wdata = wd_r;
    case (state_r)
      S_CLEAR: begin
        dm_we    = 1'b1;
        dm_addr  = clr_r;
        dm_wdata = 16'd0;
      end
      S_DECODE: begin
        dm_we = (kind_r == KIND_WRITE) && !byte_r && (addr_r != ADDR_UNLOCK)
                && (addr_r != ADDR_CMD) && data_hit && init_r;
      end
      S_BWAIT: begin
        dm_we    = 1'b1;
        dm_wdata = addr_r[0] ? {dm_rdata[15:8], wd_r[7:0]} : {wd_r[7:0], dm_rdata[7:0]};
      end
      S_VER: begin
        dm_we    = 1'b1;
        dm_addr  = DAW'(ver_r);
        dm_wdata = version_word(ver_r);
      end
      S_PRD: dm_addr = DAW'(pk_r);
      default: ;
    endcase
  end

  assign tm_we   = (state_r == S_DECODE) && (kind_r == KIND_TOC)
                   && ({1'b0, tidx_r} < 8'(MAX_TRACKS));
  assign tm_addr = (state_r == S_DECODE) ? tidx_r[TAW-1:0] : ra_r[TAW-1:0];

  cdap_ram #(.WIDTH(16), .DEPTH(DATA_WORDS)) u_data_ram (
    .clk   (clk),
    .we    (dm_we),
    .addr  (dm_addr),
    .wdata (dm_wdata),
    .rdata (dm_rdata)
  );

  cdap_ram #(.WIDTH(TOC_BITS), .DEPTH(MAX_TRACKS)) u_toc_ram (
    .clk   (clk),
    .we    (tm_we),
    .addr  (tm_addr),
    .wdata (twr_r),
    .rdata (tm_rdata)
  );

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      tcount_r    <= '0;
      init_r      <= 1'b0;
      play_r      <= 1'b0;
      pause_r     <= 1'b0;
      overlay_r   <= 1'b0;
      tn_valid_r  <= 1'b0;
      tn_r        <= '0;
      loop_r      <= 1'b0;
      end_r       <= '0;
      lsec_r      <= '0;
      cur_r       <= '0;
      busy_r      <= '0;
      res_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        tcount_r <= cfg_write_data;
      end
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == DAW'(DATA_WORDS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            kind_r    <= in_command;
            addr_r    <= in_address;
            byte_r    <= in_byte_access;
            wd_r      <= in_write_data;
            tidx_r    <= in_toc_index;
            twr_r     <= '{in_toc_start, in_toc_end, in_toc_loop_mode, in_toc_loop_offset};
            rd_r      <= '0;
            req_r     <= 1'b0;
            req_trk_r <= '0;
            req_sec_r <= '0;
            state_r   <= S_DECODE;
          end
        end
        S_DECODE: begin
          state_r <= S_DONE;
          case (kind_r)
            KIND_READ: begin
              if (overlay_r) begin
                if (addr_r >= ADDR_DATA) begin
                  if (word_ok) begin
                    state_r <= S_RDWAIT;
                  end
                end else if (addr_r >= ADDR_REGS) begin
                  case (addr_r[3:1])
                    REG_ID_A:   rd_r <= ID_WORD_A;
                    REG_ID_B:   rd_r <= ID_WORD_B;
                    REG_ID_C:   rd_r <= ID_WORD_C;
                    REG_RESULT: rd_r <= res_r;
                    REG_BUSY:   rd_r <= busy_r;
                    default:    rd_r <= 16'd0;
                  endcase
                end
              end
            end
            KIND_WRITE: begin
              if (byte_r) begin
                if (data_hit && init_r) begin
                  state_r <= S_BWAIT;
                end
              end else if (addr_r == ADDR_UNLOCK) begin
                if (wd_r == UNLOCK_WORD) begin
                  if (!init_r) begin
                    init_r     <= 1'b1;
                    play_r     <= 1'b0;
                    pause_r    <= 1'b0;
                    tn_valid_r <= 1'b0;
                  end
                  overlay_r <= 1'b1;
                end else begin
                  overlay_r <= 1'b0;
                end
              end else if (addr_r == ADDR_CMD) begin
                if (init_r) begin
                  busy_r  <= wd_r;
                  state_r <= S_CMD;
                end
              end
            end
            KIND_TICK: state_r <= S_TICK1;
            default: ;
          endcase
        end
        S_RDWAIT: begin
          rd_r    <= dm_rdata;
          state_r <= S_DONE;
        end
        S_BWAIT: state_r <= S_DONE;
        S_CMD: begin
          state_r <= S_DONE;
          pk_r    <= '0;
          ver_r   <= '0;
          case (op)
            OP_VERSION: begin
              busy_r  <= '0;
              state_r <= S_VER;
            end
            OP_PLAY, OP_PLAY_LOOP: state_r <= S_TRK_CHK;
            OP_PLAY_OFFS: begin
              pn_r    <= 3'd2;
              state_r <= S_PRD;
            end
            OP_SECTORS: begin
              pn_r    <= 3'd6;
              state_r <= S_PRD;
            end
            OP_PAUSE: begin
              pause_r <= 1'b1;
              busy_r  <= '0;
            end
            OP_RESUME: begin
              pause_r <= 1'b0;
              busy_r  <= '0;
            end
            OP_STATUS: begin
              res_r  <= play_r ? 16'h0100 : 16'h0000;
              busy_r <= '0;
            end
            OP_TRACKS: begin
              res_r  <= {1'b0, tcount_r, 8'h00};
              busy_r <= '0;
            end
            default: begin
              busy_r <= '0;
              res_r  <= '0;
            end
          endcase
        end
        S_VER: begin
          ver_r <= ver_r + 1'b1;
          if (ver_r == 3'd7) begin
            state_r <= S_DONE;
          end
        end
        S_PRD: state_r <= S_PCAP;
        S_PCAP: begin
          prm_r[pk_r] <= dm_rdata;
          pk_r        <= pk_r + 1'b1;
          if (pk_r + 1'b1 == pn_r) begin
            if (op == OP_PLAY_OFFS) begin
              state_r <= S_TRK_CHK;
            end else begin
              ra_r    <= tcount_r;
              state_r <= S_SEC_RD;
            end
          end else begin
            state_r <= S_PRD;
          end
        end
        S_TRK_CHK: begin
          if (num == 8'd0 || num > {1'b0, tcount_r}) begin
            res_r   <= '0;
            busy_r  <= '0;
            state_r <= S_DONE;
          end else begin
            tn_r       <= num[6:0] - 1'b1;
            tn_valid_r <= 1'b1;
            ra_r       <= num[6:0] - 1'b1;
            state_r    <= S_TRK_RD;
          end
        end
        S_TRK_RD: state_r <= S_TRK_USE;
        S_TRK_USE: begin
          loop_r    <= trk_loop;
          end_r     <= ent.end_sec;
          lsec_r    <= ent.start_sec + trk_offs;
          cur_r     <= ent.start_sec;
          play_r    <= 1'b1;
          pause_r   <= 1'b0;
          req_r     <= 1'b1;
          req_trk_r <= tn_r;
          req_sec_r <= ent.start_sec;
          state_r   <= S_DONE;
        end
        S_SEC_RD: state_r <= S_SEC_CHK;
        S_SEC_CHK: begin
          if (p_s[31] || ($signed(p_s) >= $signed(ent.start_sec))) begin
            res_r   <= '0;
            busy_r  <= '0;
            state_r <= S_DONE;
          end else begin
            ra_r    <= '0;
            state_r <= S_WALK_TEST;
          end
        end
        S_WALK_TEST: state_r <= (ra_r < tcount_r) ? S_WALK_RD : S_SEC_GO;
        S_WALK_RD: state_r <= S_WALK_CHK;
        S_WALK_CHK: begin
          if ($signed(ent.end_sec) <= $signed(p_s)) begin
            ra_r    <= ra_r + 1'b1;
            state_r <= S_WALK_TEST;
          end else begin
            state_r <= S_SEC_GO;
          end
        end
        S_SEC_GO: begin
          tn_r       <= ra_r;
          tn_valid_r <= 1'b1;
          loop_r     <= (num != 8'd0);
          end_r      <= p_e;
          lsec_r     <= p_l;
          cur_r      <= p_s;
          play_r     <= 1'b1;
          pause_r    <= 1'b0;
          req_r      <= 1'b1;
          req_trk_r  <= ra_r;
          req_sec_r  <= p_s;
          state_r    <= S_DONE;
        end
        S_TICK1: begin
          state_r <= S_DONE;
          if (play_r && tn_valid_r) begin
            busy_r  <= '0;
            cur_r   <= cur_r + {31'd0, !pause_r};
            em1_r   <= end_r - 32'd1;
            state_r <= S_TICK2;
          end
        end
        S_TICK2: begin
          if ($signed(cur_r) >= $signed(em1_r)) begin
            if (!loop_r) begin
              play_r     <= 1'b0;
              pause_r    <= 1'b0;
              tn_valid_r <= 1'b0;
            end else begin
              cur_r     <= lsec_r;
              play_r    <= 1'b1;
              pause_r   <= 1'b0;
              req_r     <= 1'b1;
              req_trk_r <= tn_r;
              req_sec_r <= lsec_r;
            end
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_rd_r    <= (kind_r != KIND_READ) ? 16'd0 :
                           !byte_r ? rd_r :
                           addr_r[0] ? {8'd0, rd_r[7:0]} : {8'd0, rd_r[15:8]};
            out_req_r   <= req_r;
            out_trk_r   <= req_trk_r;
            out_sec_r   <= req_sec_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_rd_r;
  assign out_play_request = out_req_r;
  assign out_play_track   = out_trk_r;
  assign out_play_sector  = out_sec_r;

  `CDAP_ASSERT_NOW(a_track_needs_init, tn_valid_r, init_r)
  `CDAP_ASSERT_NOW(a_no_data_write_idle, state_r == S_IDLE, !dm_we)
  `CDAP_ASSERT_NEXT(a_done_holds_when_full, state_r == S_DONE && out_valid_r && out_stall,
                    state_r == S_DONE)

endmodule

@@ rtl/cdap_ram.sv @@
`timescale 1ns / 1ps
module cdap_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ tb/tb_cd_audio_command_port.sv @@
`timescale 1ns / 1ps
module tb_cd_audio_command_port;
  import cdap_pkg::*;

  localparam logic [2:0] FL_INIT  = 3'b001;
  localparam logic [2:0] FL_PLAY  = 3'b010;
  localparam logic [2:0] FL_PAUSE = 3'b100;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic        byte_acc;
    logic [15:0] wdata;
    logic [6:0]  tidx;
    logic [31:0] tstart;
    logic [31:0] tend;
    logic [1:0]  tmode;
    logic [31:0] toffs;
  } bus_item_t;

  typedef struct {
    logic [15:0] read_data;
    logic        play_req;
    logic [6:0]  play_trk;
    logic [31:0] play_sec;
  } port_response_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_write_en = 1'b0;
  logic [6:0] cfg_write_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_command = '0;
  logic [15:0] in_address = '0;
  logic in_byte_access = 1'b0;
  logic [15:0] in_write_data = '0;
  logic [6:0] in_toc_index = '0;
  logic signed [31:0] in_toc_start = '0;
  logic signed [31:0] in_toc_end = '0;
  logic signed [1:0] in_toc_loop_mode = '0;
  logic signed [31:0] in_toc_loop_offset = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_read_data;
  logic out_play_request;
  logic [6:0] out_play_track;
  logic signed [31:0] out_play_sector;

  cd_audio_command_port dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_address(in_address), .in_byte_access(in_byte_access),
    .in_write_data(in_write_data), .in_toc_index(in_toc_index),
    .in_toc_start(in_toc_start), .in_toc_end(in_toc_end),
    .in_toc_loop_mode(in_toc_loop_mode), .in_toc_loop_offset(in_toc_loop_offset),
    .out_valid(out_valid), .out_stall(out_stall), .out_read_data(out_read_data),
    .out_play_request(out_play_request), .out_play_track(out_play_track),
    .out_play_sector(out_play_sector)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mirror of the controller state.
  logic [15:0] data_words [1024];
  logic [31:0] trk_start [128];
  logic [31:0] trk_end [128];
  int          trk_mode [128];
  logic [31:0] trk_offs [128];
  logic [2:0]  flags = '0;
  logic        overlay = 1'b0;
  int          track_now = -1;
  logic        looping = 1'b0;
  logic [31:0] end_sec = '0, loop_sec = '0, cur_sec = '0;
  logic [15:0] busy_word = '0, result_word = '0;
  int          track_cnt = 0;
  logic        req_valid;
  int          req_track;
  logic [31:0] req_sector;

  bus_item_t      pending_items[$];
  port_response_t expected_responses[$];
  bus_item_t      held;
  port_response_t predicted;
  int send_idle = 0, recv_idle = 0;
  int errors = 0;
  int quiet_cycles = 0;

  initial begin
    foreach (data_words[i]) data_words[i] = '0;
    foreach (trk_start[i]) begin
      trk_start[i] = '0; trk_end[i] = '0; trk_mode[i] = 0; trk_offs[i] = '0;
    end
  end

  function automatic logic [15:0] read_word(input logic [15:0] a);
    if (!overlay) return 16'h0;
    if (a >= ADDR_DATA) return data_words[(a & 16'h7ff) >> 1];
    if (a >= ADDR_REGS) begin
      case (a[3:1])
        REG_ID_A:   return ID_WORD_A;
        REG_ID_B:   return ID_WORD_B;
        REG_ID_C:   return ID_WORD_C;
        REG_RESULT: return result_word;
        REG_BUSY:   return busy_word;
        default:    return 16'h0;
      endcase
    end
    return 16'h0;
  endfunction

  task automatic start_play(input logic [31:0] sector);
    cur_sec = sector;
    flags = (flags | FL_PLAY) & ~FL_PAUSE;
    req_valid = 1'b1;
    req_track = track_now;
    req_sector = sector;
  endtask

  task automatic play_track_op(input int num, input logic [31:0] offs, input logic lp);
    if (num < 1 || num > track_cnt) begin
      result_word = '0;
      busy_word = '0;
      return;
    end
    track_now = num - 1;
    if (trk_mode[num-1] != 0) begin
      lp = trk_mode[num-1] > 0;
      offs = trk_offs[num-1];
    end
    looping = lp;
    end_sec = trk_end[num-1];
    loop_sec = trk_start[num-1] + offs;
    start_play(trk_start[num-1]);
  endtask

  task automatic play_range_op(input logic [31:0] s, input logic [31:0] e,
                               input logic [31:0] l, input logic lp);
    int i;
    i = 0;
    if ($signed(s) < 0 || $signed(s) >= $signed(trk_start[track_cnt])) begin
      result_word = '0;
      busy_word = '0;
      return;
    end
    while ($signed(trk_end[i]) <= $signed(s) && i < track_cnt) i++;
    track_now = i;
    looping = lp;
    end_sec = e;
    loop_sec = l;
    start_play(s);
  endtask

  function automatic logic [31:0] param_long(input int w);
    return {data_words[w], data_words[w+1]};
  endfunction

  task automatic run_command(input logic [15:0] d);
    busy_word = d;
    case (d[15:8])
      OP_VERSION: begin
        data_words[0] = 16'h4d45; data_words[1] = 16'h4741;
        data_words[2] = 16'h5344; data_words[3] = 16'h0104;
        data_words[4] = 16'h0700; data_words[5] = 16'hffff;
        data_words[6] = 16'h1234; data_words[7] = 16'h5678;
        busy_word = '0;
      end
      OP_PLAY:      play_track_op(d[7:0], 32'h0, 1'b0);
      OP_PLAY_LOOP: play_track_op(d[7:0], 32'h0, 1'b1);
      OP_PLAY_OFFS: play_track_op(d[7:0], param_long(0), 1'b1);
      OP_SECTORS:
        play_range_op(param_long(0), param_long(2), param_long(4), d[7:0] != 8'h0);
      OP_PAUSE: begin flags |= FL_PAUSE; busy_word = '0; end
      OP_RESUME: begin flags &= ~FL_PAUSE; busy_word = '0; end
      OP_STATUS: begin
        result_word = (flags & FL_PLAY) != 0 ? 16'h0100 : 16'h0;
        busy_word = '0;
      end
      OP_TRACKS: begin
        result_word = 16'(track_cnt << 8);
        busy_word = '0;
      end
      default: begin busy_word = '0; result_word = '0; end
    endcase
  endtask

  task automatic bus_write(input logic [15:0] a, input logic [15:0] d, input logic b);
    int w;
    w = (a & 16'h7ff) >> 1;
    if (b) begin
      if (a >= ADDR_DATA && (flags & FL_INIT) != 0) begin
        if (a[0]) data_words[w][7:0] = d[7:0];
        else data_words[w][15:8] = d[7:0];
      end
    end else if (a == ADDR_UNLOCK) begin
      if (d == UNLOCK_WORD) begin
        if ((flags & FL_INIT) == 0) begin
          flags = FL_INIT;
          track_now = -1;
        end
        overlay = 1'b1;
      end else begin
        overlay = 1'b0;
      end
    end else if (a == ADDR_CMD) begin
      if ((flags & FL_INIT) != 0) run_command(d);
    end else if (a >= ADDR_DATA && (flags & FL_INIT) != 0) begin
      data_words[w] = d;
    end
  endtask

  task automatic sector_tick();
    if (flags != 0 && track_now >= 0 && (flags & FL_PLAY) != 0) begin
      busy_word = '0;
      if ((flags & FL_PAUSE) == 0) cur_sec = cur_sec + 1;
      if ($signed(cur_sec) >= $signed(end_sec - 32'd1)) begin
        if (!looping) begin
          flags &= FL_INIT;
          track_now = -1;
        end else begin
          start_play(loop_sec);
        end
      end
    end
  endtask

  task automatic predict_response(input bus_item_t it, output port_response_t r);
    logic [15:0] rd;
    rd = '0;
    req_valid = 1'b0;
    req_track = 0;
    req_sector = '0;
    case (it.kind)
      KIND_READ: begin
        rd = read_word(it.addr & 16'hfffe);
        if (it.byte_acc) rd = it.addr[0] ? {8'h0, rd[7:0]} : {8'h0, rd[15:8]};
      end
      KIND_WRITE: bus_write(it.addr, it.wdata, it.byte_acc);
      KIND_TICK:  sector_tick();
      default: begin
        trk_start[it.tidx] = it.tstart;
        trk_end[it.tidx] = it.tend;
        trk_mode[it.tidx] = it.tmode == 2'b00 ? 0 : (it.tmode == 2'b01 ? 1 : -1);
        trk_offs[it.tidx] = it.toffs;
      end
    endcase
    r.read_data = rd;
    r.play_req = req_valid;
    r.play_trk = req_valid ? req_track[6:0] : 7'h0;
    r.play_sec = req_valid ? req_sector : 32'h0;
  endtask

  // Driver: the held item stays on the ports until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_response(held, predicted);
        expected_responses.push_back(predicted);
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
          held = pending_items.pop_front();
          in_command <= held.kind;
          in_address <= held.addr;
          in_byte_access <= held.byte_acc;
          in_write_data <= held.wdata;
          in_toc_index <= held.tidx;
          in_toc_start <= held.tstart;
          in_toc_end <= held.tend;
          in_toc_loop_mode <= held.tmode;
          in_toc_loop_offset <= held.toffs;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    port_response_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_responses.size() == 0) begin
        $display("%0t: unexpected result read_data %h", $realtime, out_read_data);
        errors++;
      end else begin
        e = expected_responses.pop_front();
        if (out_read_data !== e.read_data) begin
          $display("%0t: read_data expected %h actual %h", $realtime, e.read_data,
                   out_read_data);
          errors++;
        end
        if (out_play_request !== e.play_req) begin
          $display("%0t: play_request expected %b actual %b", $realtime, e.play_req,
                   out_play_request);
          errors++;
        end
        if (out_play_track !== e.play_trk) begin
          $display("%0t: play_track expected %0d actual %0d", $realtime, e.play_trk,
                   out_play_track);
          errors++;
        end
        if (out_play_sector !== e.play_sec) begin
          $display("%0t: play_sector expected %h actual %h", $realtime, e.play_sec,
                   out_play_sector);
          errors++;
        end
      end
    end
    out_stall <= $urandom_range(99) < recv_idle;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_cd_audio_command_port failed");
        $finish;
      end
    end
  end

  task automatic push_bus(input logic [1:0] k, input logic [15:0] a, input logic b,
                          input logic [15:0] d);
    bus_item_t it;
    it.kind = k; it.addr = a; it.byte_acc = b; it.wdata = d;
    it.tidx = 7'($urandom); it.tstart = $urandom; it.tend = $urandom;
    it.tmode = 2'($urandom_range(2) == 2 ? 3 : $urandom_range(1));
    it.toffs = $urandom;
    pending_items.push_back(it);
  endtask

  task automatic push_track(input int idx, input logic [31:0] s, input logic [31:0] e,
                            input logic [1:0] m, input logic [31:0] o);
    bus_item_t it;
    it.kind = KIND_TOC; it.addr = 16'($urandom); it.byte_acc = 1'($urandom);
    it.wdata = 16'($urandom);
    it.tidx = idx[6:0]; it.tstart = s; it.tend = e; it.tmode = m; it.toffs = o;
    pending_items.push_back(it);
  endtask

  // A plausible table entry: tracks laid out in order, short enough to run out.
  task automatic push_sane_track(input int idx);
    logic [31:0] s;
    logic [1:0] m;
    s = idx * 40 + $urandom_range(9);
    case ($urandom_range(3))
      0: m = LOOP_FORCE;
      1: m = 2'b11;
      default: m = LOOP_NONE;
    endcase
    push_track(idx, s, s + 3 + $urandom_range(30), m, $urandom_range(6));
  endtask

  task automatic push_command(input logic [7:0] op, input logic [7:0] arg);
    push_bus(KIND_WRITE, ADDR_CMD, 1'b0, {op, arg});
  endtask

  task automatic push_range_params(input logic [31:0] s, input logic [31:0] e,
                                   input logic [31:0] l);
    push_bus(KIND_WRITE, ADDR_DATA,     1'b0, s[31:16]);
    push_bus(KIND_WRITE, ADDR_DATA + 2, 1'b0, s[15:0]);
    push_bus(KIND_WRITE, ADDR_DATA + 4, 1'b0, e[31:16]);
    push_bus(KIND_WRITE, ADDR_DATA + 6, 1'b0, e[15:0]);
    push_bus(KIND_WRITE, ADDR_DATA + 8, 1'b0, l[31:16]);
    push_bus(KIND_WRITE, ADDR_DATA + 10, 1'b0, l[15:0]);
  endtask

  task automatic push_random(input int count);
    int sel;
    logic [31:0] s;
    logic [7:0] ops [10];
    ops = '{OP_VERSION, OP_PLAY, OP_PLAY_LOOP, OP_PAUSE, OP_RESUME, OP_STATUS,
            OP_PLAY_OFFS, OP_SECTORS, OP_TRACKS, 8'h00};
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 30) begin
        push_bus(KIND_TICK, 16'($urandom), 1'($urandom), 16'($urandom));
      end else if (sel < 40) begin
        push_bus(KIND_READ, 16'($urandom_range(16'hffff, 16'hf7f0)), 1'($urandom),
                 16'($urandom));
      end else if (sel < 44) begin
        push_bus(KIND_READ, 16'($urandom), 1'($urandom), 16'($urandom));
      end else if (sel < 54) begin
        push_bus(KIND_WRITE, ADDR_DATA + 16'($urandom_range(15)), 1'b0, 16'($urandom));
      end else if (sel < 58) begin
        push_bus(KIND_WRITE, 16'($urandom_range(16'hffff, 16'hf7f0)), 1'($urandom),
                 16'($urandom));
      end else if (sel < 78) begin
        ops[9] = 8'($urandom);
        case (ops[$urandom_range(9)])
          OP_SECTORS: begin
            s = $urandom_range(8) == 0 ? 32'($urandom) :
                32'($urandom_range(track_cnt * 40 + 12));
            push_range_params(s, s + $urandom_range(25), s + $urandom_range(4));
            push_command(OP_SECTORS, $urandom_range(1) ? 8'($urandom) : 8'h0);
          end
          OP_PLAY_OFFS: begin
            push_bus(KIND_WRITE, ADDR_DATA, 1'b0, $urandom_range(3) == 0 ? 16'($urandom) : 16'h0);
            push_bus(KIND_WRITE, ADDR_DATA + 2, 1'b0, 16'($urandom_range(8)));
            push_command(OP_PLAY_OFFS, 8'($urandom_range(track_cnt + 1)));
          end
          default: begin
            ops[9] = 8'($urandom);
            push_command(ops[$urandom_range(9)],
                         $urandom_range(5) == 0 ? 8'($urandom) :
                                                  8'($urandom_range(track_cnt + 1)));
          end
        endcase
      end else if (sel < 83) begin
        push_bus(KIND_WRITE, ADDR_UNLOCK, 1'b0, UNLOCK_WORD);
      end else if (sel < 85) begin
        push_bus(KIND_WRITE, ADDR_UNLOCK, 1'b0, 16'($urandom));
      end else if (sel < 89) begin
        push_bus(KIND_WRITE, 16'($urandom), 1'($urandom), 16'($urandom));
      end else if (sel < 98) begin
        push_sane_track($urandom_range(127));
      end else begin
        push_track($urandom_range(127), $urandom, $urandom, 2'($urandom_range(1)),
                   $urandom);
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_responses.size() != 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_track_count(input int v);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= 7'(v);
    track_cnt = v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_track_count(3);
    for (int i = 0; i < 128; i++) push_sane_track(i);
    // Overrides on tracks 2 and 3: forced loop and forced no loop.
    push_track(1, 100, 104, LOOP_FORCE, 2);
    push_track(2, 200, 203, 2'b11, 1);
    // Locked block: reads give zero, writes and commands are dropped.
    push_bus(KIND_READ, ADDR_UNLOCK, 1'b0, 16'h0);
    push_bus(KIND_WRITE, ADDR_DATA, 1'b0, 16'hbeef);
    push_command(OP_PLAY, 8'd1);
    push_bus(KIND_WRITE, ADDR_UNLOCK, 1'b0, 16'h1234);
    push_bus(KIND_WRITE, ADDR_UNLOCK, 1'b0, UNLOCK_WORD);
    push_bus(KIND_READ, ADDR_REGS, 1'b0, 16'h0);
    push_bus(KIND_READ, 16'hf7f6, 1'b1, 16'h0);
    push_bus(KIND_READ, 16'hf7fb, 1'b1, 16'h0);
    push_bus(KIND_READ, 16'hf7f9, 1'b0, 16'h0);
    push_command(OP_VERSION, 8'h0);
    push_bus(KIND_READ, 16'hf806, 1'b0, 16'h0);
    push_bus(KIND_READ, 16'hffff, 1'b1, 16'h0);
    push_bus(KIND_WRITE, 16'hf801, 1'b1, 16'hffab);
    push_bus(KIND_WRITE, 16'hf800, 1'b1, 16'h00cd);
    push_bus(KIND_READ, ADDR_DATA, 1'b0, 16'h0);
    push_command(OP_PLAY, 8'd1);
    push_bus(KIND_TICK, 16'h0, 1'b0, 16'h0);
    push_command(OP_PAUSE, 8'h0);
    push_bus(KIND_TICK, 16'h0, 1'b0, 16'h0);
    push_command(OP_RESUME, 8'h0);
    push_command(OP_STATUS, 8'h0);
    push_command(OP_TRACKS, 8'h0);
    push_bus(KIND_READ, 16'hf7fc, 1'b0, 16'h0);
    push_command(OP_PLAY_LOOP, 8'd2);
    for (int i = 0; i < 4; i++) push_bus(KIND_TICK, 16'h0, 1'b0, 16'h0);
    push_command(OP_PLAY_OFFS, 8'd3);
    push_command(OP_PLAY, 8'd0);
    push_command(OP_PLAY, 8'd4);
    push_command(8'h3f, 8'h0);
    push_range_params(32'd45, 32'd60, 32'd50);
    push_command(OP_SECTORS, 8'd1);
    push_range_params(32'hffff_fff0, 32'd0, 32'd0);
    push_command(OP_SECTORS, 8'd0);
    push_bus(KIND_WRITE, ADDR_UNLOCK, 1'b0, 16'h0);
    push_bus(KIND_READ, 16'hf7fe, 1'b0, 16'h0);
    wait_drained();

    write_track_count(99);
    send_idle = 37; recv_idle = 58;
    push_bus(KIND_WRITE, ADDR_UNLOCK, 1'b0, UNLOCK_WORD);
    push_random(280);
    wait_drained();

    write_track_count(0);
    send_idle = 58; recv_idle = 37;
    push_random(70);
    wait_drained();

    write_track_count($urandom_range(1, 98));
    push_random(200);
    wait_drained();

    write_track_count(12);
    send_idle = 0; recv_idle = 0;
    push_random(285);
    wait_drained();

    if (errors == 0) $display("tb_cd_audio_command_port passed");
    else $display("tb_cd_audio_command_port failed");
    $finish;
  end

endmodule
